// ----- src/bwvu_pkg.sv -----
// ----------------------------------------------------------------------------
// bwvu_pkg: shared types and constants of the byte window variance test
// Field widths, microcode word layout, control struct and the microcode ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package bwvu_pkg;

  localparam int WIN_W      = 32;
  localparam int SUM_W      = 40;
  localparam int SQ_W       = 48;
  localparam int BOUND_W    = 48;
  localparam int OUT_N_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER     = 2'd3;

  // Wide multiply: three 32-bit limbs per operand, one limb product per cycle
  localparam int LIMB_W  = 32;
  localparam int OPND_W  = 3 * LIMB_W;
  localparam int PAD_W   = 4 * LIMB_W;
  localparam int PROD_W  = 2 * LIMB_W;
  localparam int SH_W    = 3;
  localparam int PHASE_W = 4;
  localparam int PC_W    = 4;

  localparam logic [PHASE_W-1:0] PHASE_ISSUE_END = 4'd9;
  localparam logic [PHASE_W-1:0] PHASE_STORE     = 4'd10;

  localparam logic [PC_W-1:0] PC_FIN = 4'd9;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  typedef enum logic [2:0] {OP_CHKFEW, OP_MUL, OP_DIFF, OP_TEST, OP_FIN} op_t;

  typedef enum logic [2:0] {
    SRC_N, SRC_S1, SRC_S2, SRC_M, SRC_D, SRC_N2, SRC_LB, SRC_UB
  } src_t;

  typedef enum logic [2:0] {DST_P1, DST_P2, DST_STAT, DST_N2, DST_LO, DST_HI} dst_t;

  typedef struct packed {
    op_t             op;
    src_t            a_sel;
    src_t            b_sel;
    dst_t            dst;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [1:0] i;
    logic [1:0] j;
  } limb_t;

  typedef struct packed {
    logic  mul_issue;
    limb_t limb;
    logic  acc_clr;
    logic  store;
    src_t  a_sel;
    src_t  b_sel;
    dst_t  dst;
    logic  do_diff;
    logic  do_test;
    logic  fin_load;
  } dp_ctl_t;

  typedef struct packed {
    logic too_few;
    logic out_room;
  } dp_stat_t;

  // Evaluation program run once per file
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_FIN, a_sel: SRC_N, b_sel: SRC_N, dst: DST_P1, target: PC_FIN};
    unique case (pc)
      4'd0: w.op = OP_CHKFEW;
      4'd1: w = '{op: OP_MUL, a_sel: SRC_N,  b_sel: SRC_S2, dst: DST_P1,   target: PC_FIN};
      4'd2: w = '{op: OP_MUL, a_sel: SRC_S1, b_sel: SRC_S1, dst: DST_P2,   target: PC_FIN};
      4'd3: w.op = OP_DIFF;
      4'd4: w = '{op: OP_MUL, a_sel: SRC_M,  b_sel: SRC_D,  dst: DST_STAT, target: PC_FIN};
      4'd5: w = '{op: OP_MUL, a_sel: SRC_N,  b_sel: SRC_N,  dst: DST_N2,   target: PC_FIN};
      4'd6: w = '{op: OP_MUL, a_sel: SRC_LB, b_sel: SRC_N2, dst: DST_LO,   target: PC_FIN};
      4'd7: w = '{op: OP_MUL, a_sel: SRC_UB, b_sel: SRC_N2, dst: DST_HI,   target: PC_FIN};
      4'd8: w.op = OP_TEST;
      default: w.op = OP_FIN;
    endcase
    return w;
  endfunction

  // Limb pair for each issue phase of a wide multiply
  function automatic limb_t limb_pos(input logic [PHASE_W-1:0] phase);
    limb_t l;
    l = '0;
    unique case (phase)
      4'd0: l = '{i: 2'd0, j: 2'd0};
      4'd1: l = '{i: 2'd0, j: 2'd1};
      4'd2: l = '{i: 2'd0, j: 2'd2};
      4'd3: l = '{i: 2'd1, j: 2'd0};
      4'd4: l = '{i: 2'd1, j: 2'd1};
      4'd5: l = '{i: 2'd1, j: 2'd2};
      4'd6: l = '{i: 2'd2, j: 2'd0};
      4'd7: l = '{i: 2'd2, j: 2'd1};
      4'd8: l = '{i: 2'd2, j: 2'd2};
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- src/bwvu_accum.sv -----
// ----------------------------------------------------------------------------
// bwvu_accum: per-byte window accumulation
// Tracks file position, window count, byte sum and square sum, all saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module bwvu_accum
  import bwvu_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  take,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  end_of_file,
  input  wire logic [WIN_W-1:0]      window_start,
  input  wire logic [WIN_W-1:0]      window_end,
  output logic      [COUNT_BITS-1:0] count_upd,
  output logic      [SUM_W-1:0]      sum_upd,
  output logic      [SQ_W-1:0]       sq_upd
);

  localparam int CMP_W = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;

  logic [COUNT_BITS-1:0] position_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SQ_W-1:0]       sq_r;

  logic [COUNT_BITS-1:0] position_upd;
  logic                  in_window;
  logic [SUM_W:0]        sum_wide;
  logic [SQ_W:0]         sq_wide;
  logic [15:0]           byte_sq;

  always_comb begin
    in_window = (window_end <= window_start) ||
                ((CMP_W'(position_r) >= CMP_W'(window_start)) &&
                 (CMP_W'(position_r) <  CMP_W'(window_end)));
    byte_sq   = 16'(data_byte) * 16'(data_byte);
    sum_wide  = {1'b0, sum_r} + (SUM_W + 1)'(data_byte);
    sq_wide   = {1'b0, sq_r} + (SQ_W + 1)'(byte_sq);

    sum_upd   = sum_r;
    sq_upd    = sq_r;
    count_upd = count_r;
    if (in_window) begin
      sum_upd   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      sq_upd    = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];
      count_upd = (&count_r) ? count_r : count_r + COUNT_BITS'(1);
    end
    position_upd = (&position_r) ? position_r : position_r + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      count_r    <= '0;
      sum_r      <= '0;
      sq_r       <= '0;
    end else if (take) begin
      // clear on the final byte; its totals go out through the *_upd ports
      if (end_of_file) begin
        position_r <= '0;
        count_r    <= '0;
        sum_r      <= '0;
        sq_r       <= '0;
      end else begin
        position_r <= position_upd;
        count_r    <= count_upd;
        sum_r      <= sum_upd;
        sq_r       <= sq_upd;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/bwvu_seq.sv -----
// ----------------------------------------------------------------------------
// bwvu_seq: microcode sequencer for the end-of-file evaluation
// Step counter, limb phase counter and ROM lookup drive the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bwvu_seq
  import bwvu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_ctl_t       ctl,
  output logic          busy
);

  seq_state_t           state_r, state_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  uword_t               word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    word      = ucode_rom(pc_r);
    state_nxt = state_r;
    pc_nxt    = pc_r;
    phase_nxt = phase_r;
    ctl       = '0;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = '0;
          phase_nxt = '0;
        end
      end
      SEQ_RUN: begin
        ctl.a_sel = word.a_sel;
        ctl.b_sel = word.b_sel;
        ctl.dst   = word.dst;
        unique case (word.op)
          OP_CHKFEW: pc_nxt = stat.too_few ? word.target : pc_r + PC_W'(1);
          OP_MUL: begin
            ctl.mul_issue = phase_r < PHASE_ISSUE_END;
            ctl.limb      = limb_pos(phase_r);
            ctl.acc_clr   = phase_r == '0;
            ctl.store     = phase_r == PHASE_STORE;
            if (phase_r == PHASE_STORE) begin
              phase_nxt = '0;
              pc_nxt    = pc_r + PC_W'(1);
            end else begin
              phase_nxt = phase_r + PHASE_W'(1);
            end
          end
          OP_DIFF: begin
            ctl.do_diff = 1'b1;
            pc_nxt      = pc_r + PC_W'(1);
          end
          OP_TEST: begin
            ctl.do_test = 1'b1;
            pc_nxt      = pc_r + PC_W'(1);
          end
          OP_FIN: begin
            // hold here until the output register has room
            ctl.fin_load = stat.out_room;
            if (stat.out_room) state_nxt = SEQ_IDLE;
          end
          default: state_nxt = SEQ_IDLE;
        endcase
      end
    endcase
  end

  assign busy = state_r == SEQ_RUN;

endmodule

`default_nettype wire

// ----- src/bwvu_datapath.sv -----
// ----------------------------------------------------------------------------
// bwvu_datapath: limb multiplier, accumulator, work registers and result
// One 32x32 product per cycle, registered, then added into the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module bwvu_datapath
  import bwvu_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [COUNT_BITS-1:0] n_in,
  input  wire logic [SUM_W-1:0]      s1_in,
  input  wire logic [SQ_W-1:0]       s2_in,
  input  wire logic [BOUND_W-1:0]    lower_bound,
  input  wire logic [BOUND_W-1:0]    upper_bound,
  input  wire dp_ctl_t               ctl,
  output dp_stat_t                   stat,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic                       out_uniform,
  output logic                       out_too_few,
  output logic      [OUT_N_W-1:0]    out_sample_count,
  output logic      [SUM_W-1:0]      out_byte_total,
  output logic      [SQ_W-1:0]       out_square_total
);

  localparam int P_W    = (COUNT_BITS + SQ_W > 2 * SUM_W) ? COUNT_BITS + SQ_W : 2 * SUM_W;
  localparam int M_W    = COUNT_BITS + 4;
  localparam int STAT_W = M_W + P_W;
  localparam int N2_W   = 2 * COUNT_BITS;
  localparam int LO_W   = BOUND_W + N2_W;
  localparam int ACC_W  = STAT_W;
  localparam int CMP_W  = (COUNT_BITS > OUT_N_W) ? COUNT_BITS : OUT_N_W;

  logic [COUNT_BITS-1:0] n_cap_r;
  logic [SUM_W-1:0]      s1_cap_r;
  logic [SQ_W-1:0]       s2_cap_r;
  logic                  too_few_r;
  logic                  uniform_r;
  logic [M_W-1:0]        m_r;
  logic [P_W-1:0]        p1_r, p2_r, d_r;
  logic [N2_W-1:0]       n2_r;
  logic [STAT_W-1:0]     stat_r;
  logic [LO_W-1:0]       lo_r, hi_r;
  logic [PROD_W-1:0]     prod_r;
  logic [SH_W-1:0]       sh_r;
  logic                  add_en_r;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic                  out_valid_r;

  logic [OPND_W-1:0]     a_opnd, b_opnd;
  logic [PAD_W-1:0]      a_pad, b_pad;
  logic [LIMB_W-1:0]     a_limb, b_limb;
  logic [2*OPND_W-1:0]   prod_ext;
  logic [COUNT_BITS-1:0] n_less1;
  logic [M_W-1:0]        m_nxt;
  logic [CMP_W-1:0]      n_ext;

  // Operand select
  always_comb begin
    unique case (ctl.a_sel)
      SRC_N:  a_opnd = OPND_W'(n_cap_r);
      SRC_S1: a_opnd = OPND_W'(s1_cap_r);
      SRC_S2: a_opnd = OPND_W'(s2_cap_r);
      SRC_M:  a_opnd = OPND_W'(m_r);
      SRC_D:  a_opnd = OPND_W'(d_r);
      SRC_N2: a_opnd = OPND_W'(n2_r);
      SRC_LB: a_opnd = OPND_W'(lower_bound);
      SRC_UB: a_opnd = OPND_W'(upper_bound);
    endcase
  end

  always_comb begin
    unique case (ctl.b_sel)
      SRC_N:  b_opnd = OPND_W'(n_cap_r);
      SRC_S1: b_opnd = OPND_W'(s1_cap_r);
      SRC_S2: b_opnd = OPND_W'(s2_cap_r);
      SRC_M:  b_opnd = OPND_W'(m_r);
      SRC_D:  b_opnd = OPND_W'(d_r);
      SRC_N2: b_opnd = OPND_W'(n2_r);
      SRC_LB: b_opnd = OPND_W'(lower_bound);
      SRC_UB: b_opnd = OPND_W'(upper_bound);
    endcase
  end

  always_comb begin
    a_pad    = PAD_W'(a_opnd);
    b_pad    = PAD_W'(b_opnd);
    a_limb   = a_pad[LIMB_W*ctl.limb.i +: LIMB_W];
    b_limb   = b_pad[LIMB_W*ctl.limb.j +: LIMB_W];
    prod_ext = (2 * OPND_W)'(prod_r) << (sh_r * LIMB_W);
    acc_nxt  = acc_r;
    if (ctl.acc_clr) acc_nxt = '0;
    else if (add_en_r) acc_nxt = acc_r + prod_ext[ACC_W-1:0];
    n_less1  = n_cap_r - COUNT_BITS'(1);
    m_nxt    = (M_W'(n_less1) << 3) + (M_W'(n_less1) << 2);
    n_ext    = CMP_W'(n_cap_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_en_r <= 1'b0;
    end else begin
      add_en_r <= ctl.mul_issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_limb * b_limb;
    sh_r   <= SH_W'({1'b0, ctl.limb.i} + {1'b0, ctl.limb.j});
    acc_r  <= acc_nxt;

    if (start) begin
      n_cap_r   <= n_in;
      s1_cap_r  <= s1_in;
      s2_cap_r  <= s2_in;
      too_few_r <= n_in < COUNT_BITS'(2);
      uniform_r <= 1'b0;
    end

    if (ctl.store) begin
      unique case (ctl.dst)
        DST_P1:   p1_r   <= acc_r[P_W-1:0];
        DST_P2:   p2_r   <= acc_r[P_W-1:0];
        DST_STAT: stat_r <= acc_r[STAT_W-1:0];
        DST_N2:   n2_r   <= acc_r[N2_W-1:0];
        DST_LO:   lo_r   <= acc_r[LO_W-1:0];
        DST_HI:   hi_r   <= acc_r[LO_W-1:0];
        default: ;
      endcase
    end

    // clamp a negative difference to zero; only reachable after saturation
    if (ctl.do_diff) begin
      d_r <= (p1_r >= p2_r) ? p1_r - p2_r : '0;
      m_r <= m_nxt;
    end

    if (ctl.do_test) begin
      uniform_r <= !((ACC_W'(stat_r) < ACC_W'(lo_r)) || (ACC_W'(stat_r) > ACC_W'(hi_r)));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_load) begin
      out_uniform      <= uniform_r;
      out_too_few      <= too_few_r;
      out_sample_count <= (n_ext > CMP_W'(32'hffff_ffff)) ? {OUT_N_W{1'b1}}
                                                          : n_ext[OUT_N_W-1:0];
      out_byte_total   <= s1_cap_r;
      out_square_total <= s2_cap_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.too_few  = too_few_r;
  assign stat.out_room = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

// ----- src/byte_window_variance_uniformity_test.sv -----
// ----------------------------------------------------------------------------
// byte_window_variance_uniformity_test: windowed byte variance check
// Sums bytes and squares over a position window and tests the variance
// against Q16 chi-squared bounds at end of file.
// ----------------------------------------------------------------------------
// Bytes of one file stream in one per cycle; in_end_of_file marks the last.
// Bytes at positions [window_start, window_end) are counted (the whole file
// when window_end is not above window_start). The final byte starts the
// evaluation: D = n*S2 - S1^2, and the file is reported uniform unless
// 12*(n-1)*D < lower*n^2 or > upper*n^2. Bytes are taken only while
// in_stall is low; the final byte holds it high while the microcode runs
// (only the count check and finish step with under two bytes counted) and
// while the result register waits on out_stall. Six wide multiplies share
// one 32x32 multiplier, each walking nine limb products plus a drain and a
// store step, under a ten-step microcode program. The result sits in an
// output register, so the next file's bytes are taken while it waits.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_window_variance_uniformity_test
  import bwvu_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // byte stream
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_end_of_file,
  // result
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_uniform,
  output logic                       out_too_few,
  output logic      [OUT_N_W-1:0]    out_sample_count,
  output logic      [SUM_W-1:0]      out_byte_total,
  output logic      [SQ_W-1:0]       out_square_total,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [WIN_W-1:0]      win_start_r;
  logic [WIN_W-1:0]      win_end_r;
  logic [BOUND_W-1:0]    lower_r;
  logic [BOUND_W-1:0]    upper_r;

  logic                  take;
  logic                  start;
  logic                  busy;
  logic [COUNT_BITS-1:0] count_upd;
  logic [SUM_W-1:0]      sum_upd;
  logic [SQ_W-1:0]       sq_upd;
  dp_ctl_t               ctl;
  dp_stat_t              stat;

  // Configuration registers; the upper bound resets wide open
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_end_r   <= '0;
      lower_r     <= '0;
      upper_r     <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIN_START: win_start_r <= cfg_wdata[WIN_W-1:0];
        CFG_WIN_END:   win_end_r   <= cfg_wdata[WIN_W-1:0];
        CFG_LOWER:     lower_r     <= cfg_wdata[BOUND_W-1:0];
        CFG_UPPER:     upper_r     <= cfg_wdata[BOUND_W-1:0];
      endcase
    end
  end

  // Stall input while the evaluation program runs
  assign in_stall = busy;
  assign take     = in_valid && !in_stall;
  assign start    = take && in_end_of_file;

  // Advance the window totals per byte; clear them on the final byte
  bwvu_accum #(
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .data_byte    (in_data_byte),
    .end_of_file  (in_end_of_file),
    .window_start (win_start_r),
    .window_end   (win_end_r),
    .count_upd    (count_upd),
    .sum_upd      (sum_upd),
    .sq_upd       (sq_upd)
  );

  // Step through the evaluation microcode
  bwvu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Capture totals at the final byte, run the wide math, hold the result
  bwvu_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .n_in             (count_upd),
    .s1_in            (sum_upd),
    .s2_in            (sq_upd),
    .lower_bound      (lower_r),
    .upper_bound      (upper_r),
    .ctl              (ctl),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_uniform      (out_uniform),
    .out_too_few      (out_too_few),
    .out_sample_count (out_sample_count),
    .out_byte_total   (out_byte_total),
    .out_square_total (out_square_total)
  );

endmodule

`default_nettype wire

// ----- tb/tb_byte_window_variance_uniformity_test.sv -----
// ----------------------------------------------------------------------------
// tb_byte_window_variance_uniformity_test: self-checking bench for the test
// Streams files of bytes through the block and predicts each end-of-file
// verdict from a bit-accurate model. Each verdict is compared field by field
// across a series of window and bound settings and several idle patterns.
// ----------------------------------------------------------------------------
module tb_byte_window_variance_uniformity_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bwvu_pkg::*;

  localparam int NPHASES     = 12;    // register settings after the directed part
  localparam int PHASE_BYTES = 120;   // at least this many random bytes per setting, whole files only
  localparam int SETTLE      = 80;    // extra wait after the last verdict of a drain
  localparam int LIMIT       = 2000000;
  localparam int WIDE_W      = 192;   // room for 12*(n-1)*D and bound*n^2
  localparam int NROWS       = 14;

  // One end-of-file verdict, in the order of the result ports
  typedef struct packed {
    logic               uniform;
    logic               too_few;
    logic [OUT_N_W-1:0] count;
    logic [SUM_W-1:0]   total;
    logic [SQ_W-1:0]    squares;
  } verdict_t;

  // Directed row: one byte, plus a hand-written verdict when typed is set
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       typed;
    verdict_t   want;
  } row_t;

  // Byte patterns used to fill a random file
  typedef enum int {FILL_NOISE, FILL_NARROW, FILL_FLAT, FILL_RAILS} fill_t;

  localparam verdict_t NO_CHECK = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic                  in_end_of_file = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_uniform;
  logic                  out_too_few;
  logic [OUT_N_W-1:0]    out_sample_count;
  logic [SUM_W-1:0]      out_byte_total;
  logic [SQ_W-1:0]       out_square_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the registers, at their reset values
  logic [WIN_W-1:0]   win_start = '0;
  logic [WIN_W-1:0]   win_end = '0;
  logic [BOUND_W-1:0] lower_q16 = '0;
  logic [BOUND_W-1:0] upper_q16 = '1;

  // Predictor copy of the accumulators
  logic [WIN_W-1:0] byte_pos = '0;
  logic [WIN_W-1:0] n_counted = '0;
  logic [SUM_W-1:0] run_sum = '0;
  logic [SQ_W-1:0]  run_sq = '0;

  verdict_t    pending_verdicts[$];
  row_t        script [NROWS];
  int          errors = 0;
  int unsigned cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  always #6 clk = ~clk;

  byte_window_variance_uniformity_test #(
    .COUNT_BITS(32)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_uniform      (out_uniform),
    .out_too_few      (out_too_few),
    .out_sample_count (out_sample_count),
    .out_byte_total   (out_byte_total),
    .out_square_total (out_square_total),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Fold one accepted byte into the running statistics; on the last byte of a
  // file, form the verdict and clear the accumulators for the next file.
  task automatic absorb_byte(input logic [7:0] b, input logic eof,
                             output logic done, output verdict_t v);
    logic              whole;
    logic              hit;
    logic [15:0]       b_sq;
    logic [SUM_W:0]    sum_x;
    logic [SQ_W:0]     sq_x;
    logic [WIN_W:0]    cnt_x;
    logic [WIN_W:0]    pos_x;
    logic [WIDE_W-1:0] n, s1, s2, lw, uw, ns2, s1sq, diff, stat, n2, lo, hi;
    whole = (win_end <= win_start);
    hit = whole || (byte_pos >= win_start && byte_pos < win_end);
    if (hit) begin
      // saturate every accumulator at its width
      b_sq = b * b;
      sum_x = {1'b0, run_sum} + b;
      run_sum = sum_x[SUM_W] ? '1 : sum_x[SUM_W-1:0];
      sq_x = {1'b0, run_sq} + b_sq;
      run_sq = sq_x[SQ_W] ? '1 : sq_x[SQ_W-1:0];
      cnt_x = {1'b0, n_counted} + 1'b1;
      n_counted = cnt_x[WIN_W] ? '1 : cnt_x[WIN_W-1:0];
    end
    pos_x = {1'b0, byte_pos} + 1'b1;
    byte_pos = pos_x[WIN_W] ? '1 : pos_x[WIN_W-1:0];
    done = eof;
    v = '0;
    if (eof) begin
      v.too_few = (n_counted < 2);
      if (!v.too_few) begin
        n = n_counted;
        s1 = run_sum;
        s2 = run_sq;
        lw = lower_q16;
        uw = upper_q16;
        ns2 = n * s2;
        s1sq = s1 * s1;
        // D below zero only follows saturation; treat it as zero
        diff = (ns2 >= s1sq) ? ns2 - s1sq : '0;
        stat = 12 * (n - 1) * diff;
        n2 = n * n;
        lo = lw * n2;
        hi = uw * n2;
        v.uniform = !(stat < lo || stat > hi);
      end
      v.count = n_counted;
      v.total = run_sum;
      v.squares = run_sq;
      byte_pos = '0;
      n_counted = '0;
      run_sum = '0;
      run_sq = '0;
    end
  endtask

  // Write one register, then mirror it into the predictor masked to its width
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_WIN_START: win_start = val[WIN_W-1:0];
      CFG_WIN_END:   win_end = val[WIN_W-1:0];
      CFG_LOWER:     lower_q16 = val[BOUND_W-1:0];
      CFG_UPPER:     upper_q16 = val[BOUND_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one byte, hold it until accepted, then queue its verdict if any
  task automatic send_byte(input logic [7:0] b, input logic eof,
                           input logic typed, input verdict_t want);
    logic     done;
    verdict_t v;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    absorb_byte(b, eof, done, v);
    if (done) pending_verdicts.push_back(typed ? want : v);
  endtask

  // Drop valid, wait for every queued verdict, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result side: check each accepted result, then pick the next stall
  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t ns: result with no verdict pending, actual count %0h",
                 $time, out_sample_count);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("uniform", want.uniform, out_uniform);
        check_field("too_few", want.too_few, out_too_few);
        check_field("sample_count", want.count, out_sample_count);
        check_field("byte_total", want.total, out_byte_total);
        check_field("square_total", want.squares, out_square_total);
      end
    end
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [WIN_W-1:0]   ws, wend;
    logic [BOUND_W-1:0] lo, hi;
    logic [7:0]         base, b;
    fill_t              style;
    int                 len, sent;

    // Directed files under reset settings: whole file, bounds 0 to all ones.
    // Two-byte files there are always uniform, a one-byte file is too few.
    script = '{
      {8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 32'd1, 40'd255, 48'd65025},
      {8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 32'd1, 40'd0,   48'd0},
      {8'h00, 1'b0, 1'b0, NO_CHECK},
      {8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 32'd2, 40'd0,   48'd0},
      {8'hFF, 1'b0, 1'b0, NO_CHECK},
      {8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd2, 40'd510, 48'd130050},
      {8'h00, 1'b0, 1'b0, NO_CHECK},
      {8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd2, 40'd255, 48'd65025},
      {8'h55, 1'b0, 1'b0, NO_CHECK},
      {8'hAA, 1'b0, 1'b0, NO_CHECK},
      {8'h01, 1'b0, 1'b0, NO_CHECK},
      {8'h80, 1'b0, 1'b0, NO_CHECK},
      {8'h7F, 1'b0, 1'b0, NO_CHECK},
      {8'hFE, 1'b1, 1'b0, NO_CHECK}
    };

    // Hold reset at the start of the run, once
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < NROWS; k++) begin
      send_byte(script[k].data, script[k].eof, script[k].typed, script[k].want);
    end
    drain();

    for (int ph = 0; ph < NPHASES; ph++) begin
      // Pick the window and bounds; fixed extremes first, then random ones
      // placed around the spread that uniform bytes give (about 2^16 per dof)
      case (ph)
        0: begin ws = 0; wend = 0; lo = 0; hi = '1; end
        1: begin ws = 2; wend = 9; lo = 0; hi = '1; end
        2: begin ws = 5; wend = 200; lo = 48'h2_0000; hi = 48'h3C_0000; end
        3: begin ws = 0; wend = 1; lo = 0; hi = '1; end
        4: begin ws = 32'hFFFF_FFFE; wend = 32'hFFFF_FFFF; lo = 0; hi = '1; end
        5: begin ws = 9; wend = 3; lo = '1; hi = '1; end
        6: begin ws = 0; wend = 0; lo = 0; hi = 0; end
        7: begin ws = '1; wend = 0; lo = '1; hi = 0; end
        default: begin
          ws = $urandom_range(0, 6);
          wend = $urandom_range(1) ? ws + $urandom_range(2, 30) : $urandom_range(0, ws);
          lo = 48'(65536) * $urandom_range(0, 30);
          hi = lo + 48'(65536) * $urandom_range(0, 150) + $urandom_range(0, 65535);
        end
      endcase
      // Junk in the upper bits of the window words must be masked off
      write_reg(CFG_WIN_START, {16'($urandom), ws});
      write_reg(CFG_WIN_END, {16'($urandom), wend});
      write_reg(CFG_LOWER, lo);
      write_reg(CFG_UPPER, hi);
      cfg_we <= 1'b0;

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase

      // Whole files only, so the block is idle when the phase drains
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if ($urandom_range(9) == 0) len = 1;
        else if ($urandom_range(24) == 0) len = $urandom_range(41, 250);
        else len = $urandom_range(2, 40);
        style = fill_t'($urandom_range(3));
        base = $urandom;
        for (int k = 0; k < len; k++) begin
          case (style)
            FILL_NOISE:  b = $urandom;
            FILL_NARROW: b = base + $urandom_range(3);
            FILL_FLAT:   b = base;
            default:     b = $urandom_range(1) ? 8'hFF : 8'h00;
          endcase
          send_byte(b, k == len - 1, 1'b0, NO_CHECK);
        end
        sent += len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
